### rtl/core/rfum_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ring FIFO with usage metrics.
package rfum_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int WORD_BITS_DEF = 64;
    localparam int LEVEL_W       = 10;
    localparam int CNT_W         = 64;
    localparam int DATA_W        = 64;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL_PUSH  = 2'd1,
        ST_EMPTY_POP  = 2'd2
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] push_word;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  pop_word;
        logic [LEVEL_W-1:0] occupancy;
        logic               is_empty;
        logic               is_full;
        logic [LEVEL_W-1:0] peak_occupancy;
        logic [CNT_W-1:0]   push_count;
        logic [CNT_W-1:0]   pop_count;
        logic [CNT_W-1:0]   refused_push_count;
    } out_item_t;

endpackage

### rtl/core/rfum_slot_ram.sv
`timescale 1ns / 1ps
// Simple dual-port slot memory with a registered read port.
module rfum_slot_ram
    import rfum_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the read word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ring_fifo_with_usage_metrics.sv
`timescale 1ns / 1ps
// Top level of the ring FIFO with usage metrics.
// A circular FIFO of DEPTH slots (a power of two) that keeps one slot free, so it
// holds at most DEPTH-1 words. Each input item is a push or a pop and yields exactly
// one result item in the cycle after it is accepted, carrying the status, the popped
// word, the occupancy with empty and full flags, the peak occupancy and three
// wrapping 64-bit event counters. The block takes one item per cycle as long as the
// result side takes each result: pointers and counters update at acceptance, and the
// popped word comes out of the slot memory's registered read port in the following
// cycle. A finished result waits in the output register while the next item is
// accepted as long as the result side takes it in the same cycle. The slot memory
// needs no clearing after reset: a slot is read only after a push has written it.
module ring_fifo_with_usage_metrics
    import rfum_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
    localparam logic [PTR_W-1:0] FULL_LVL = {PTR_W{1'b1}};

    // architectural state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0] push_cnt_reg, push_cnt_next;
    logic [CNT_W-1:0] pop_cnt_reg, pop_cnt_next;
    logic [CNT_W-1:0] refused_cnt_reg, refused_cnt_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    status_t          status_reg;
    logic             pop_ok_reg;
    logic [PTR_W-1:0] level_reg;

    logic             accept;
    logic [PTR_W-1:0] head_inc;
    logic             is_full_now;
    logic             is_empty_now;
    logic             do_push;
    logic             do_pop;
    status_t          status_next;
    logic [PTR_W-1:0] level_next;
    logic [EXT_W-1:0] level_ext;
    logic [EXT_W-1:0] peak_ext;
    logic [WORD_BITS-1:0] rd_word;

    // take a new item whenever the result register is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign head_inc     = head_reg + PTR_W'(1);
    assign is_full_now  = (head_inc == tail_reg);
    assign is_empty_now = (head_reg == tail_reg);
    assign do_push      = accept && (s_item.op == OP_PUSH) && !is_full_now;
    assign do_pop       = accept && (s_item.op == OP_POP) && !is_empty_now;

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        peak_next        = peak_reg;
        push_cnt_next    = push_cnt_reg;
        pop_cnt_next     = pop_cnt_reg;
        refused_cnt_next = refused_cnt_reg;
        status_next      = ST_OK;
        m_valid_next     = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next = 1'b1;
            case (s_item.op)
                OP_PUSH: begin
                    if (is_full_now) begin
                        // refuse and count, leave the pointers alone
                        refused_cnt_next = refused_cnt_reg + CNT_W'(1);
                        status_next      = ST_FULL_PUSH;
                    end else begin
                        head_next     = head_inc;
                        push_cnt_next = push_cnt_reg + CNT_W'(1);
                    end
                end
                default: begin
                    if (is_empty_now) begin
                        status_next = ST_EMPTY_POP;
                    end else begin
                        tail_next    = tail_reg + PTR_W'(1);
                        pop_cnt_next = pop_cnt_reg + CNT_W'(1);
                    end
                end
            endcase
        end

        // level after this item; peak moves only on a successful push
        level_next = head_next - tail_next;
        if (do_push && (level_next > peak_reg)) begin
            peak_next = level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            tail_reg        <= '0;
            peak_reg        <= '0;
            push_cnt_reg    <= '0;
            pop_cnt_reg     <= '0;
            refused_cnt_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            peak_reg        <= peak_next;
            push_cnt_reg    <= push_cnt_next;
            pop_cnt_reg     <= pop_cnt_next;
            refused_cnt_reg <= refused_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // capture result fields with the item; hold them while the result stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            pop_ok_reg <= do_pop;
            level_reg  <= level_next;
        end
    end

    // slot store: write at head on push, read at tail on pop
    rfum_slot_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (head_reg),
        .wr_data (s_item.push_word[WORD_BITS-1:0]),
        .rd_en   (do_pop),
        .rd_addr (tail_reg),
        .rd_data (rd_word)
    );

    assign level_ext = EXT_W'(level_reg);
    assign peak_ext  = EXT_W'(peak_reg);

    // counters and peak already hold this item's values while the result waits,
    // since no new item is accepted until the result is taken
    assign m_valid                    = m_valid_reg;
    assign m_item.status              = status_reg;
    assign m_item.pop_word            = pop_ok_reg ? DATA_W'(rd_word) : '0;
    assign m_item.occupancy           = level_ext[LEVEL_W-1:0];
    assign m_item.is_empty            = (level_reg == '0);
    assign m_item.is_full             = (level_reg == FULL_LVL);
    assign m_item.peak_occupancy      = peak_ext[LEVEL_W-1:0];
    assign m_item.push_count          = push_cnt_reg;
    assign m_item.pop_count           = pop_cnt_reg;
    assign m_item.refused_push_count  = refused_cnt_reg;

endmodule
